// ===== design/sorted_key_value_table_defines.svh =====
// Assertion macros for the port checker file.
`ifndef SORTED_KEY_VALUE_TABLE_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_DEFINES_SVH
// Concurrent assertion on the rising clock, muted during reset.
`define SKV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same, checked through reset as well.
`define SKV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== design/skvt_pkg.sv =====
// Package: constants, codes and payload types of the sorted key/value table.
package skvt_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEY_W = 24;
  localparam int unsigned TAG_W = 32;
  localparam int unsigned QTY_W = 32;
  localparam int unsigned ENTRY_W = KEY_W + TAG_W + QTY_W;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_SEARCH = 3'd1,
    OP_UPDATE = 3'd2,
    OP_LIST   = 3'd3,
    OP_ERASE  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_EXISTS  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic [KEY_W-1:0]  part_id;
    logic [TAG_W-1:0]  name_tag;
    logic signed [QTY_W-1:0] initial_quantity;
    logic signed [QTY_W-1:0] quantity_change;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [KEY_W-1:0]  result_part;
    logic [TAG_W-1:0]  result_tag;
    logic signed [QTY_W-1:0] result_quantity;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [QTY_W-1:0] qty;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_WRITE,
    S_LIST,
    S_RESULT
  } state_t;

  function automatic logic [QTY_W-1:0] sat_add(input logic [QTY_W-1:0] a,
                                               input logic [QTY_W-1:0] b);
    logic [QTY_W:0] s;
    s = {a[QTY_W-1], a} + {b[QTY_W-1], b};
    if (s[QTY_W] != s[QTY_W-1]) begin
      sat_add = s[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}} : {1'b0, {(QTY_W-1){1'b1}}};
    end else begin
      sat_add = s[QTY_W-1:0];
    end
  endfunction

endpackage

// ===== design/skvt_mem.sv =====
// Entry memory: one write port, one registered read port.
module skvt_mem #(
  parameter int unsigned DEPTH = skvt_pkg::CAPACITY_DEF,
  parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  skvt_pkg::entry_t      wdata,
  input  logic [AW-1:0]         raddr,
  output skvt_pkg::entry_t      rdata
);
  import skvt_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/skvt_ctrl.sv =====
// Sequencer: scans, shifts and reports over the entry memory.
module skvt_ctrl #(
  parameter int unsigned CAPACITY = skvt_pkg::CAPACITY_DEF,
  parameter int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  skvt_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output skvt_pkg::out_item_t  out_item,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output skvt_pkg::entry_t     mem_wdata,
  output logic [AW-1:0]        mem_raddr,
  input  skvt_pkg::entry_t     mem_rdata
);
  import skvt_pkg::*;

  state_t    state_r, state_nxt;
  in_item_t  item_r, item_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic      hit_r, hit_nxt;
  entry_t    hit_e_r, hit_e_nxt;
  out_item_t res_r, res_nxt;
  logic      ov_r, ov_nxt;

  logic [2:0] op;
  assign op = item_r.operation;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_item.operation == OP_LIST) begin
            state_nxt = (count_r == '0) ? S_RESULT : S_LIST;
          end else if (in_item.operation > OP_ERASE) begin
            state_nxt = S_IDLE;
          end else if (in_item.operation == OP_INSERT && count_r >= CW'(CAPACITY)) begin
            state_nxt = S_RESULT;
          end else begin
            state_nxt = (count_r == '0) ? S_DECIDE : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_r + 1'b1 >= count_r || mem_rdata.key >= item_r.part_id) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_DECIDE: begin
        if (!hit_r) begin
          state_nxt = (op == OP_INSERT) ?
                      ((pos_r == count_r) ? S_WRITE : S_SHIFT_UP) : S_RESULT;
        end else if (op == OP_UPDATE) begin
          state_nxt = S_WRITE;
        end else if (op == OP_ERASE) begin
          state_nxt = (pos_r + 1'b1 >= count_r) ? S_RESULT : S_SHIFT_DN;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_SHIFT_UP: state_nxt = (idx_r == pos_r) ? S_WRITE : S_SHIFT_UP;
      S_SHIFT_DN: state_nxt = (idx_r + 2'd2 >= count_r) ? S_RESULT : S_SHIFT_DN;
      S_WRITE:    state_nxt = S_RESULT;
      S_LIST:     state_nxt = (idx_r >= count_r) ? S_IDLE : S_LIST;
      S_RESULT:   state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_nxt  = item_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    hit_nxt   = hit_r;
    hit_e_nxt = hit_e_r;
    res_nxt   = res_r;
    ov_nxt    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = hit_e_r;
    mem_raddr = '0;
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          idx_nxt  = '0;
          pos_nxt  = count_r;
          hit_nxt  = 1'b0;
          mem_raddr = '0;
          res_nxt = '{status: ST_FULL, result_part: in_item.part_id,
                      result_tag: '0, result_quantity: '0, last: 1'b1};
          if (in_item.operation == OP_LIST && count_r == '0) begin
            res_nxt = '{status: ST_MISSING, result_part: '0,
                        result_tag: '0, result_quantity: '0, last: 1'b1};
          end
          if (in_item.operation == OP_LIST) begin
            idx_nxt = CW'(1);
          end
        end
      end
      S_SCAN: begin
        mem_raddr = AW'(idx_r + 1'b1);
        if (mem_rdata.key >= item_r.part_id) begin
          pos_nxt   = idx_r;
          hit_nxt   = (mem_rdata.key == item_r.part_id);
          hit_e_nxt = mem_rdata;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DECIDE: begin
        idx_nxt = count_r - 1'b1;
        mem_raddr = AW'(count_r - 1'b1);
        if (!hit_r) begin
          res_nxt = '{status: ST_MISSING, result_part: item_r.part_id,
                      result_tag: '0, result_quantity: '0, last: 1'b1};
          if (op == OP_INSERT) begin
            res_nxt = '{status: ST_OK, result_part: item_r.part_id,
                        result_tag: item_r.name_tag,
                        result_quantity: item_r.initial_quantity, last: 1'b1};
          end
        end else begin
          res_nxt = '{status: (op == OP_INSERT) ? ST_EXISTS : ST_OK,
                      result_part: hit_e_r.key, result_tag: hit_e_r.tag,
                      result_quantity: hit_e_r.qty, last: 1'b1};
          if (op == OP_UPDATE) begin
            res_nxt.result_quantity = sat_add(hit_e_r.qty, item_r.quantity_change);
          end
          if (op == OP_ERASE) begin
            idx_nxt   = pos_r;
            mem_raddr = AW'(pos_r + 1'b1);
            if (pos_r + 1'b1 >= count_r) begin
              count_nxt = count_r - 1'b1;
            end
          end
        end
      end
      S_SHIFT_UP: begin
        // rdata holds entry idx; move it up one place
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_r + 1'b1);
        mem_wdata = mem_rdata;
        if (idx_r != pos_r) begin
          idx_nxt   = idx_r - 1'b1;
          mem_raddr = AW'(idx_r - 1'b1);
        end
      end
      S_SHIFT_DN: begin
        // rdata holds entry idx+1; move it down one place
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_r);
        mem_wdata = mem_rdata;
        idx_nxt   = idx_r + 1'b1;
        mem_raddr = AW'(idx_r + 2'd2);
        if (idx_r + 2'd2 >= count_r) begin
          count_nxt = count_r - 1'b1;
        end
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_r);
        if (op == OP_INSERT) begin
          mem_wdata = '{key: item_r.part_id, tag: item_r.name_tag,
                        qty: item_r.initial_quantity};
          count_nxt = count_r + 1'b1;
        end else begin
          mem_wdata = '{key: hit_e_r.key, tag: hit_e_r.tag, qty: res_r.result_quantity};
        end
      end
      S_LIST: begin
        mem_raddr = AW'(idx_r);
        if (idx_r <= count_r) begin
          ov_nxt  = 1'b1;
          res_nxt = '{status: ST_OK, result_part: mem_rdata.key,
                      result_tag: mem_rdata.tag, result_quantity: mem_rdata.qty,
                      last: (idx_r == count_r)};
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_RESULT: begin
        ov_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
    item_r  <= item_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    hit_r   <= hit_nxt;
    hit_e_r <= hit_e_nxt;
    res_r   <= res_nxt;
  end

  assign out_valid = ov_r;
  assign out_item  = res_r;
endmodule

// ===== design/sorted_key_value_table.sv =====
// Top level: sorted key/value table over one entry memory.
// One command at a time: busy is high from the transfer until the last result
// is strobed out, and an unused operation code is dropped without a result.
// The receiver cannot stall, so each result is shown for one cycle on
// out_valid. A search, update or erase scans from the first entry to the
// match place; insert also moves each later entry up and erase moves each
// later entry down; list reads every entry. All cost comes from the single
// memory read port, one entry per cycle.
module sorted_key_value_table #(
  parameter int unsigned CAPACITY = skvt_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  skvt_pkg::in_item_t  in_item,
  output logic                out_valid,
  output skvt_pkg::out_item_t out_item
);
  import skvt_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  skvt_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .mem_we, .mem_waddr, .mem_wdata, .mem_raddr, .mem_rdata
  );

  skvt_mem #(.DEPTH(CAPACITY)) u_mem (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );
endmodule

// ===== design/skvt_checker.sv =====
// Port checker for the sorted key/value table, bound to the top level.
`include "sorted_key_value_table_defines.svh"
module skvt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input skvt_pkg::in_item_t  in_item,
  input logic                out_valid,
  input skvt_pkg::out_item_t out_item
);
  import skvt_pkg::*;

  `SKV_ASSERT(a_res_busy, out_valid |-> $past(busy), "result without command")
  `SKV_ASSERT(a_err_last, (out_valid && out_item.status != ST_OK) |-> out_item.last, "err")
  `SKV_ASSERT(a_last_free, (out_valid && out_item.last) |-> !busy, "busy at last result")
  `SKV_ASSERT(a_start_busy, (start && !busy && in_item.operation <= OP_ERASE) |=> busy, "idle")
  `SKV_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_valid && !busy, "reset not clean")
endmodule

bind sorted_key_value_table skvt_checker u_skvt_checker (
  .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item
);

// ===== tb/tb_sorted_key_value_table.sv =====
// Testbench for the sorted key/value table: directed table plus random commands.
`timescale 1ns / 1ps

module tb_sorted_key_value_table;
  import skvt_pkg::*;

  localparam int CAP = int'(CAPACITY_DEF);
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;

  sorted_key_value_table u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #10 clk = ~clk;

  int unsigned tbl_n;
  logic [KEY_W-1:0] tbl_key [CAP];
  logic [TAG_W-1:0] tbl_tag [CAP];
  logic [QTY_W-1:0] tbl_qty [CAP];

  out_item_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int n_items = 0;
  int n_results = 0;

  function automatic out_item_t mk(logic [1:0] st, logic [KEY_W-1:0] p,
                                   logic [TAG_W-1:0] t, logic [QTY_W-1:0] q, logic l);
    out_item_t r;
    r.status = st; r.result_part = p; r.result_tag = t; r.result_quantity = q; r.last = l;
    return r;
  endfunction

  function automatic logic [QTY_W-1:0] add_clamp(logic [QTY_W-1:0] a, logic [QTY_W-1:0] b);
    longint s;
    s = longint'($signed(a)) + longint'($signed(b));
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  task automatic predict_table(input in_item_t it);
    int unsigned pos;
    int i;
    bit hit;
    pos = 0;
    if (it.operation == OP_LIST) begin
      if (tbl_n == 0) pending_results.push_back(mk(ST_MISSING, 0, 0, 0, 1'b1));
      for (i = 0; i < tbl_n; i++)
        pending_results.push_back(mk(ST_OK, tbl_key[i], tbl_tag[i], tbl_qty[i],
                                     i + 1 == tbl_n));
      return;
    end
    if (it.operation > OP_ERASE) return;
    while (pos < tbl_n && tbl_key[pos] < it.part_id) pos++;
    hit = pos < tbl_n && tbl_key[pos] == it.part_id;
    if (it.operation == OP_INSERT) begin
      if (tbl_n >= CAP)
        pending_results.push_back(mk(ST_FULL, it.part_id, 0, 0, 1'b1));
      else if (hit)
        pending_results.push_back(mk(ST_EXISTS, it.part_id, tbl_tag[pos],
                                     tbl_qty[pos], 1'b1));
      else begin
        for (i = tbl_n; i > pos; i--) begin
          tbl_key[i] = tbl_key[i-1]; tbl_tag[i] = tbl_tag[i-1]; tbl_qty[i] = tbl_qty[i-1];
        end
        tbl_key[pos] = it.part_id; tbl_tag[pos] = it.name_tag;
        tbl_qty[pos] = it.initial_quantity;
        tbl_n++;
        pending_results.push_back(mk(ST_OK, it.part_id, it.name_tag,
                                     it.initial_quantity, 1'b1));
      end
      return;
    end
    if (!hit) begin
      pending_results.push_back(mk(ST_MISSING, it.part_id, 0, 0, 1'b1));
      return;
    end
    if (it.operation == OP_UPDATE) tbl_qty[pos] = add_clamp(tbl_qty[pos], it.quantity_change);
    pending_results.push_back(mk(ST_OK, it.part_id, tbl_tag[pos], tbl_qty[pos], 1'b1));
    if (it.operation == OP_ERASE) begin
      for (i = pos; i + 1 < tbl_n; i++) begin
        tbl_key[i] = tbl_key[i+1]; tbl_tag[i] = tbl_tag[i+1]; tbl_qty[i] = tbl_qty[i+1];
      end
      tbl_n--;
    end
  endtask

  task automatic report_mismatch(input string what, input out_item_t got,
                                 input out_item_t want);
    errors++;
    $display("mismatch %0s: got %0h want %0h (result %0d)", what, got, want, n_results);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_results.size() == 0) report_mismatch("unexpected result", out_item, '0);
      else begin
        out_item_t e;
        e = pending_results.pop_front();
        if (out_item !== e) report_mismatch("result", out_item, e);
      end
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // direct check of values readable at a glance, on top of the predictor
  task automatic send_cmd(input in_item_t it, input bit has_want, input out_item_t want);
    int gap;
    gap = $urandom_range(0, 16);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (has_want) begin
      out_item_t p;
      int unsigned sv;
      sv = pending_results.size();
      predict_table(it);
      p = pending_results[sv];
      if (p !== want) report_mismatch("directed row", p, want);
    end else predict_table(it);
    in_item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
  endtask

  function automatic in_item_t cmd(logic [2:0] op, logic [KEY_W-1:0] p,
                                   logic [31:0] t, logic [31:0] q, logic [31:0] c);
    in_item_t it;
    it.operation = op; it.part_id = p; it.name_tag = t;
    it.initial_quantity = q; it.quantity_change = c;
    return it;
  endfunction

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk);
  endtask

  typedef struct {
    in_item_t it;
    bit has_want;
    out_item_t want;
  } row_t;

  row_t rows[$];
  logic [KEY_W-1:0] used_keys[$];

  initial begin
    in_item_t it;
    int i, k, r;
    logic [2:0] op;
    logic [KEY_W-1:0] key;
    tbl_n = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    rows.push_back('{cmd(OP_LIST, 0, 0, 0, 0), 1, mk(ST_MISSING, 0, 0, 0, 1)});
    rows.push_back('{cmd(OP_SEARCH, 24'h123, 0, 0, 0), 1, mk(ST_MISSING, 24'h123, 0, 0, 1)});
    rows.push_back('{cmd(OP_ERASE, 24'hFFFFFF, 0, 0, 0), 1,
                     mk(ST_MISSING, 24'hFFFFFF, 0, 0, 1)});
    rows.push_back('{cmd(OP_UPDATE, 0, 0, 0, 5), 1, mk(ST_MISSING, 0, 0, 0, 1)});
    rows.push_back('{cmd(OP_INSERT, 24'hFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 0), 1,
                     mk(ST_OK, 24'hFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 1)});
    rows.push_back('{cmd(OP_INSERT, 0, 0, 32'h80000000, 32'hFFFFFFFF), 1,
                     mk(ST_OK, 0, 0, 32'h80000000, 1)});
    rows.push_back('{cmd(OP_INSERT, 24'h800000, 32'hA5A5A5A5, 32'd10, 0), 0, '0});
    rows.push_back('{cmd(OP_INSERT, 0, 32'h1, 32'h1, 0), 1,
                     mk(ST_EXISTS, 0, 0, 32'h80000000, 1)});
    rows.push_back('{cmd(OP_UPDATE, 24'hFFFFFF, 0, 0, 32'd1), 1,
                     mk(ST_OK, 24'hFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 1)});
    rows.push_back('{cmd(OP_UPDATE, 0, 0, 0, 32'h80000000), 1,
                     mk(ST_OK, 0, 0, 32'h80000000, 1)});
    rows.push_back('{cmd(OP_UPDATE, 24'h800000, 0, 0, 32'hFFFFFFF0), 0, '0});
    rows.push_back('{cmd(OP_SEARCH, 24'h800000, 0, 0, 0), 0, '0});
    rows.push_back('{cmd(OP_LIST, 0, 0, 0, 0), 0, '0});
    rows.push_back('{cmd(3'd5, 24'h5, 5, 5, 5), 0, '0});
    rows.push_back('{cmd(3'd6, 0, 0, 0, 0), 0, '0});
    rows.push_back('{cmd(3'd7, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF), 0, '0});
    rows.push_back('{cmd(OP_ERASE, 24'h800000, 0, 0, 0), 0, '0});
    rows.push_back('{cmd(OP_ERASE, 0, 0, 0, 0), 0, '0});
    rows.push_back('{cmd(OP_LIST, 0, 0, 0, 0), 0, '0});
    foreach (rows[i]) send_cmd(rows[i].it, rows[i].has_want, rows[i].want);

    // fill to capacity, then full-table and list-of-64 cases
    for (k = 0; tbl_n < CAP; k++)
      send_cmd(cmd(OP_INSERT, KEY_W'($urandom), $urandom, $urandom, $urandom), 0, '0);
    send_cmd(cmd(OP_INSERT, tbl_key[3], 1, 1, 1), 1, mk(ST_FULL, tbl_key[3], 0, 0, 1));
    send_cmd(cmd(OP_INSERT, 24'h000007, 1, 1, 1), 1, mk(ST_FULL, 24'h7, 0, 0, 1));
    send_cmd(cmd(OP_LIST, 0, 0, 0, 0), 0, '0);
    drain_results();
    repeat (200) @(negedge clk);
    while (tbl_n > 0) send_cmd(cmd(OP_ERASE, tbl_key[$urandom_range(0, tbl_n - 1)],
                                   $urandom, $urandom, $urandom), 0, '0);

    // random: mostly hits on a small key set, some noise
    for (i = 0; i < 100; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) op = OP_INSERT;
      else if (r < 55) op = OP_SEARCH;
      else if (r < 75) op = OP_UPDATE;
      else if (r < 90) op = OP_ERASE;
      else if (r < 96) op = OP_LIST;
      else op = 3'($urandom_range(5, 7));
      if (tbl_n > 0 && $urandom_range(0, 3) != 0)
        key = tbl_key[$urandom_range(0, tbl_n - 1)];
      else if ($urandom_range(0, 1)) key = $urandom_range(0, 40);
      else key = KEY_W'($urandom);
      it = cmd(op, key, $urandom, $urandom, $urandom);
      if ($urandom_range(0, 7) == 0) it.quantity_change = $urandom_range(0, 1) ?
          32'h7FFFFFFF : 32'h80000000;
      send_cmd(it, 0, '0);
      if (i == 50) drain_results();
    end

    drain_results();
    repeat (300) @(negedge clk);
    $display("covered %0d commands and %0d results: all operations, full and empty table,",
             n_items, n_results);
    $display("duplicate and missing keys, saturating updates and unused codes");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
